// File: hdl/cct_pkg.sv
// shared types and constants for the csv tokenizer with column cut
package cct_pkg;

    localparam int unsigned MAX_COLUMNS_DEF = 64;
    localparam int unsigned SEL_W           = 64;
    localparam int unsigned SEL_IDX_W       = $clog2(SEL_W);
    localparam int unsigned CFG_DATA_W      = 64;
    localparam int unsigned CFG_ADDR_W      = 5;
    localparam int unsigned OUT_TDATA_W     = 16;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam logic [7:0]       QUOTE_RST = 8'd34;
    localparam logic [7:0]       SEP_RST   = 8'd44;
    localparam logic [SEL_W-1:0] SEL_RST   = 64'd1;
    localparam logic             CUT_RST   = 1'b1;

    typedef enum logic [1:0] {
        REG_QUOTE = 2'd0,
        REG_SEP   = 2'd1,
        REG_SEL   = 2'd2,
        REG_CUT   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic       run_last;
        logic       keep_byte;
        logic       field_end;
        logic       field_start;
        logic       record_end;
        logic       escape_quote;
        logic       in_quoted;
        logic [7:0] out_byte;
    } t_result;

endpackage

// File: hdl/csv_tokenizer_column_cut_core.sv
// csv tokenizer top level: quote tracking, field and record marks, column cut
//
// Takes one byte per clock while s_axis tready is high and gives one result
// beat per byte, one position behind the input: a byte is described when the
// next byte arrives, which serves as lookahead for doubled quotes. A beat with
// tlast set closes the text; the block then holds s_axis tready low while it
// describes that final byte (tlast set on its result) and returns all parsing
// state to its reset values, so the next byte begins a new text. Results pass
// through an output register with a skid stage, so one more result is taken
// while a result waits. Result tdata bits: [7:0] byte,
// [8] in quotes, [9] escape quote, [10] record end, [11] field start,
// [12] field end, [13] keep, [15:14] zero. Configuration registers sit on
// the apb port at 8-byte steps: quote, separator, column bitmap, cut mode;
// write them only while the block is idle.
module csv_tokenizer_column_cut_core
    import cct_pkg::*;
#(
    parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // s_axis
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [7:0]             i_s_axis_tdata,   // data_byte
    input  logic                   i_s_axis_tlast,   // end_of_text
    // m_axis
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // out_byte, in_quoted, escape_quote,
                                                     // record_end, field_start, field_end,
                                                     // keep_byte, zero pad
    output logic                   o_m_axis_tlast,   // run_last
    // apb
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int unsigned CW = $clog2(MAX_COLUMNS + 1);
    localparam logic [SEL_W-1:0] SEL_MASK = (MAX_COLUMNS >= SEL_W) ? {SEL_W{1'b1}}
                                          : ((SEL_W'(1) << MAX_COLUMNS) - SEL_W'(1));

    // configuration
    logic [7:0]       r_quote;
    logic [7:0]       r_sep;
    logic [SEL_W-1:0] r_sel;
    logic             r_cut;
    t_reg_idx         w_ridx;
    logic             w_cfg_wr;

    // parse state
    logic [7:0]       r_held_byte;
    logic             r_held_valid;
    logic             r_final_pend;
    logic             r_parity;
    logic             r_inside;
    logic             r_last_esc;
    logic             r_last_cr;
    logic             r_last_final;
    logic [CW-1:0]    r_col;
    logic             r_closed;

    logic             n_inside;
    logic             n_last_final;
    logic [CW-1:0]    n_col;
    logic             n_closed;

    logic             w_sk_ready;
    logic             w_acc;
    logic             w_emit;
    t_result          w_res;
    t_result          w_out;

    logic             w_q, w_odd, w_even, w_esc, w_open, w_close, w_inq, w_unq;
    logic             w_lf, w_cr, w_sep, w_rec, w_follow, w_fin;
    logic             w_next_q, w_fc, w_col_in, w_col_sel, w_is_top, w_any, w_keep;
    logic [SEL_W-1:0] w_chosen;
    logic [6:0]       w_col7;

    assign pready   = 1'b1;
    assign w_ridx   = t_reg_idx'(paddr[4:3]);
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote <= QUOTE_RST;
            r_sep   <= SEP_RST;
            r_sel   <= SEL_RST;
            r_cut   <= CUT_RST;
        end else if (w_cfg_wr) begin
            case (w_ridx)
                REG_QUOTE: r_quote <= pwdata[7:0];
                REG_SEP:   r_sep   <= pwdata[7:0];
                REG_SEL:   r_sel   <= pwdata;
                REG_CUT:   r_cut   <= pwdata[0];
                default:   r_cut   <= r_cut;
            endcase
        end
    end

    always_comb begin
        case (w_ridx)
            REG_QUOTE: prdata = {{(CFG_DATA_W-8){1'b0}}, r_quote};
            REG_SEP:   prdata = {{(CFG_DATA_W-8){1'b0}}, r_sep};
            REG_SEL:   prdata = r_sel;
            REG_CUT:   prdata = {{(CFG_DATA_W-1){1'b0}}, r_cut};
            default:   prdata = '0;
        endcase
    end

    // handshake
    assign o_s_axis_tready = w_sk_ready && !r_final_pend;
    assign w_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_emit = (w_acc && r_held_valid) || (r_final_pend && w_sk_ready);

    // byte classification of the held byte
    assign w_next_q = !r_final_pend && (i_s_axis_tdata == r_quote);
    assign w_q      = (r_held_byte == r_quote);
    assign w_odd    = w_q && !r_parity;
    assign w_even   = w_q && r_parity;
    assign w_esc    = w_even && w_next_q;
    assign w_open   = w_odd && !r_last_esc;
    assign w_close  = w_even && !w_esc;
    assign w_inq    = r_inside || w_open;
    assign w_unq    = !w_inq;
    assign w_lf     = (r_held_byte == CH_LF);
    assign w_cr     = (r_held_byte == CH_CR);
    assign w_sep    = (r_held_byte == r_sep);
    assign w_rec    = w_lf && w_unq;
    assign w_follow = ((w_sep || w_cr) && w_unq) || (w_rec && !r_last_cr);
    assign w_fin    = (w_sep || w_lf) && w_unq;

    // column selection
    assign w_chosen  = r_sel & SEL_MASK;
    assign w_any     = |w_chosen;
    assign w_col7    = 7'(r_col);
    assign w_col_in  = (r_col < CW'(MAX_COLUMNS));
    assign w_col_sel = w_col_in && w_chosen[w_col7[SEL_IDX_W-1:0]];
    assign w_is_top  = ((w_chosen & ({SEL_W{1'b1}} << (w_col7 + 7'd1))) == '0);
    assign w_fc      = r_last_final ? 1'b0 : r_closed;

    always_comb begin
        w_keep = w_col_sel && !w_fc && !(w_follow && r_cut && w_is_top);
        if (w_rec && r_cut && w_any) begin
            w_keep = 1'b1;
        end
    end

    always_comb begin
        n_inside     = w_inq && !w_close;
        n_last_final = w_fin;
        n_col        = r_col;
        n_closed     = w_fc;
        if (w_rec) begin
            n_col    = '0;
            n_closed = 1'b0;
        end else if (w_fin) begin
            if (w_col_in) begin
                n_col = r_col + CW'(1);
            end
            n_closed = 1'b0;
        end else if (w_follow) begin
            n_closed = 1'b1;
        end
    end

    assign w_res.out_byte     = r_held_byte;
    assign w_res.in_quoted    = w_inq;
    assign w_res.escape_quote = w_esc;
    assign w_res.record_end   = w_rec;
    assign w_res.field_start  = r_last_final;
    assign w_res.field_end    = w_follow;
    assign w_res.keep_byte    = w_keep;
    assign w_res.run_last     = r_final_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_final_pend <= 1'b0;
            r_parity     <= 1'b0;
            r_inside     <= 1'b0;
            r_last_esc   <= 1'b0;
            r_last_cr    <= 1'b0;
            r_last_final <= 1'b1;
            r_col        <= '0;
            r_closed     <= 1'b0;
        end else if (r_final_pend) begin
            if (w_sk_ready) begin
                r_held_valid <= 1'b0;
                r_final_pend <= 1'b0;
                r_parity     <= 1'b0;
                r_inside     <= 1'b0;
                r_last_esc   <= 1'b0;
                r_last_cr    <= 1'b0;
                r_last_final <= 1'b1;
                r_col        <= '0;
                r_closed     <= 1'b0;
            end
        end else if (w_acc) begin
            r_held_valid <= 1'b1;
            r_final_pend <= i_s_axis_tlast;
            if (r_held_valid) begin
                r_parity     <= r_parity ^ w_q;
                r_inside     <= n_inside;
                r_last_esc   <= w_esc;
                r_last_cr    <= w_cr;
                r_last_final <= n_last_final;
                r_col        <= n_col;
                r_closed     <= n_closed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_held_byte <= i_s_axis_tdata;
        end
    end

    cct_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (w_emit),
        .o_in_ready  (w_sk_ready),
        .i_in_data   (w_res),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (w_out)
    );

    assign o_m_axis_tdata = {2'b00, w_out.keep_byte, w_out.field_end, w_out.field_start,
                             w_out.record_end, w_out.escape_quote, w_out.in_quoted,
                             w_out.out_byte};
    assign o_m_axis_tlast = w_out.run_last;

    a_final_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_final_pend |-> r_held_valid)
        else $error("final byte pending without a held byte");

    a_final_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_final_pend |-> !o_s_axis_tready)
        else $error("input accepted while final byte pending");

    a_text_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_final_pend && w_sk_ready) |=>
            (!r_held_valid && r_last_final && !r_inside && !r_parity && r_col == '0))
        else $error("parse state not cleared after end of text");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= CW'(MAX_COLUMNS))
        else $error("column index beyond limit");

    a_emit_only_with_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> r_held_valid)
        else $error("result produced without a held byte");

endmodule

// File: hdl/cct_skid.sv
// output register with skid stage for the result beats
module cct_skid
    import cct_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_result i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out_data
);

    logic    r_valid;
    logic    r_skid_valid;
    t_result r_data;
    t_result r_skid;
    logic    w_take;

    assign o_in_ready  = !r_skid_valid;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;
    assign w_take      = i_in_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_out_ready || !r_valid) begin
            if (r_skid_valid) begin
                r_valid      <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_valid <= w_take;
            end
        end else if (w_take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_out_ready || !r_valid) begin
            if (r_skid_valid) begin
                r_data <= r_skid;
            end else if (w_take) begin
                r_data <= i_in_data;
            end
        end else if (w_take) begin
            r_skid <= i_in_data;
        end
    end

endmodule

// File: tb/tb_csv_tokenizer_column_cut_core.sv
// testbench for the csv tokenizer with column cut: stream stimulus, byte mark prediction, checks
module tb_csv_tokenizer_column_cut_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cct_pkg::*;

    localparam int TARGET_BYTES = 1750;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 4;

    // predicts the marks of each byte and holds them until the block returns them
    class csv_marks_board;
        logic [7:0]       quote_ch;
        logic [7:0]       sep_ch;
        logic [SEL_W-1:0] col_sel;
        logic             cut;
        logic [7:0]       held_byte;
        bit               held_valid;
        bit               parity;
        bit               in_span;
        bit               prev_escape;
        bit               prev_cr;
        bit               prev_final;
        int               col_idx;
        bit               col_closed;
        t_result          pending_marks[$];
        int               errors;

        function new();
            quote_ch = QUOTE_RST;
            sep_ch   = SEP_RST;
            col_sel  = SEL_RST;
            cut      = CUT_RST;
            errors   = 0;
            restart_text();
        endfunction

        function void restart_text();
            held_byte   = '0;
            held_valid  = 0;
            parity      = 0;
            in_span     = 0;
            prev_escape = 0;
            prev_cr     = 0;
            prev_final  = 1;
            col_idx     = 0;
            col_closed  = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [63:0] v);
            case (idx)
                REG_QUOTE: quote_ch = v[7:0];
                REG_SEP:   sep_ch   = v[7:0];
                REG_SEL:   col_sel  = v;
                REG_CUT:   cut      = v[0];
                default: ;
            endcase
        endfunction

        function t_result mark_byte(logic [7:0] b, bit next_quote, bit last);
            bit      q, esc, open, close, inq, lf, cr, sep, rec, follow, fin, fstart;
            bit      sel_hit, keep;
            int      top;
            t_result r;
            q      = (b == quote_ch);
            esc    = q && parity && next_quote;
            open   = q && !parity && !prev_escape;
            close  = q && parity && !esc;
            inq    = in_span || open;
            lf     = (b == CH_LF);
            cr     = (b == CH_CR);
            sep    = (b == sep_ch);
            rec    = lf && !inq;
            follow = ((sep || cr) && !inq) || (rec && !prev_cr);
            fin    = (sep || lf) && !inq;
            fstart = prev_final;
            top = -1;
            for (int i = 0; i < MAX_COLUMNS_DEF; i++) begin
                if (col_sel[i]) top = i;
            end
            sel_hit = (col_idx < MAX_COLUMNS_DEF) ? col_sel[col_idx[5:0]] : 1'b0;
            if (fstart) col_closed = 0;
            keep = sel_hit && !col_closed && !(follow && cut && col_idx == top);
            if (rec && cut && col_sel != '0) keep = 1;
            in_span = inq && !close;
            if (q) parity = !parity;
            prev_escape = esc;
            prev_cr     = cr;
            prev_final  = fin;
            if (rec) begin
                col_idx    = 0;
                col_closed = 0;
            end else if (fin) begin
                if (col_idx < MAX_COLUMNS_DEF) col_idx++;
                col_closed = 0;
            end else if (follow) begin
                col_closed = 1;
            end
            r.out_byte     = b;
            r.in_quoted    = inq;
            r.escape_quote = esc;
            r.record_end   = rec;
            r.field_start  = fstart;
            r.field_end    = follow;
            r.keep_byte    = keep;
            r.run_last     = last;
            return r;
        endfunction

        function void accept_byte(logic [7:0] b, bit eot);
            if (held_valid) pending_marks.push_back(mark_byte(held_byte, b == quote_ch, 0));
            if (eot) begin
                pending_marks.push_back(mark_byte(b, 0, 1));
                restart_text();
            end else begin
                held_byte  = b;
                held_valid = 1;
            end
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %h got %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_marks(logic [OUT_TDATA_W-1:0] tdata, logic tlast);
            t_result want;
            if (pending_marks.size() == 0) begin
                $display("%0t: result beat with none expected, tdata %h tlast %b",
                         $time, tdata, tlast);
                errors++;
                return;
            end
            want = pending_marks.pop_front();
            check_field("out_byte", want.out_byte, tdata[7:0]);
            check_field("in_quoted", want.in_quoted, tdata[8]);
            check_field("escape_quote", want.escape_quote, tdata[9]);
            check_field("record_end", want.record_end, tdata[10]);
            check_field("field_start", want.field_start, tdata[11]);
            check_field("field_end", want.field_end, tdata[12]);
            check_field("keep_byte", want.keep_byte, tdata[13]);
            check_field("pad", 8'h00, tdata[15:14]);
            check_field("run_last", want.run_last, tlast);
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [7:0]             i_s_axis_tdata;   // data_byte
    logic                   i_s_axis_tlast;   // end_of_text
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;   // out_byte, in_quoted, escape_quote, record_end,
                                              // field_start, field_end, keep_byte, zero pad
    logic                   o_m_axis_tlast;   // run_last
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CFG_ADDR_W-1:0]  paddr;
    logic [CFG_DATA_W-1:0]  pwdata;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    csv_marks_board sb;
    bit             calm;
    int             bytes_sent;
    int             cycle_count = 0;
    logic [7:0]     text_bytes[$];

    csv_tokenizer_column_cut_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_axis_tready = calm || ($urandom_range(99) >= 25);
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
                sb.check_marks(o_m_axis_tdata, o_m_axis_tlast);
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic eot);
        if (!calm && $urandom_range(99) < 25) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = b;
        i_s_axis_tlast  = eot;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.accept_byte(b, eot);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_bytes.size(); i++)
            send_beat(text_bytes[i], i == text_bytes.size() - 1);
    endtask

    task automatic drain();
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tlast  = 1'b0;
        while (sb.pending_marks.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic reg_write(input t_reg_idx idx, input logic [63:0] v);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_setting(input logic [7:0] q, input logic [7:0] s,
                                 input logic [63:0] sel, input logic c);
        reg_write(REG_QUOTE, {56'd0, q});
        reg_write(REG_SEP, {56'd0, s});
        reg_write(REG_SEL, sel);
        reg_write(REG_CUT, {63'd0, c});
    endtask

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
    endfunction

    function automatic logic [7:0] plain_char(logic [7:0] qc, logic [7:0] sc);
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == qc || c == sc || c == CH_CR || c == CH_LF);
        return c;
    endfunction

    function automatic void add_field(logic [7:0] qc, logic [7:0] sc);
        int n;
        n = $urandom_range(0, 6);
        if ($urandom_range(3) == 0) begin
            text_bytes.push_back(qc);
            repeat (n) begin
                case ($urandom_range(7))
                    0: begin
                        text_bytes.push_back(qc);
                        text_bytes.push_back(qc);
                    end
                    1: text_bytes.push_back(sc);
                    2: text_bytes.push_back(CH_LF);
                    3: text_bytes.push_back(CH_CR);
                    default: text_bytes.push_back(plain_char(qc, sc));
                endcase
            end
            text_bytes.push_back(qc);
        end else begin
            repeat (n) text_bytes.push_back(plain_char(qc, sc));
        end
    endfunction

    function automatic void build_text();
        logic [7:0] qc, sc;
        int         n, cols;
        qc = sb.quote_ch;
        sc = sb.sep_ch;
        text_bytes.delete();
        if ($urandom_range(99) < 15) begin
            // noise and broken quoting
            n = $urandom_range(1, 20);
            repeat (n) begin
                case ($urandom_range(5))
                    0: text_bytes.push_back(qc);
                    1: text_bytes.push_back(sc);
                    2: text_bytes.push_back(CH_CR);
                    3: text_bytes.push_back(CH_LF);
                    default: text_bytes.push_back(8'($urandom_range(255)));
                endcase
            end
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                cols = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
                for (int c = 0; c < cols; c++) begin
                    if (c > 0) text_bytes.push_back(sc);
                    add_field(qc, sc);
                end
                case ($urandom_range(19))
                    0, 1:       ;
                    2:          text_bytes.push_back(CH_CR);
                    3, 4, 5, 6, 7, 8, 9: begin
                        text_bytes.push_back(CH_CR);
                        text_bytes.push_back(CH_LF);
                    end
                    default:    text_bytes.push_back(CH_LF);
                endcase
            end
        end
        if (text_bytes.size() == 0) text_bytes.push_back(plain_char(qc, sc));
    endfunction

    task automatic run_phase(input int target);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < target) begin
            build_text();
            send_text();
        end
        drain();
    endtask

    initial begin
        logic [7:0]  q, s;
        logic [63:0] sel;
        int          phase;
        sb              = new();
        calm            = 1'b0;
        bytes_sent      = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: quoted escape, cr lf, bare lf, byte extremes
        text_bytes.delete();
        push_str("\"a\"\"b\",c\r\nd\n");
        text_bytes.push_back(8'h00);
        text_bytes.push_back(8'hFF);
        send_text();
        text_bytes.delete();
        push_str(",");
        send_text();
        text_bytes.delete();
        push_str("x,\"\"");
        send_text();
        text_bytes.delete();
        push_str("\"a,\nb\"\n,");
        send_text();
        drain();

        apply_setting(8'h27, 8'h09, 64'h5, 1'b0);
        run_phase(80);
        apply_setting(8'h00, 8'hFF, '1, 1'b1);
        run_phase(80);
        apply_setting(8'hFF, 8'h00, '0, 1'b1);
        run_phase(80);
        apply_setting(8'd34, 8'd44, 64'h8000_0000_0000_0001, 1'b1);
        run_phase(150);
        apply_setting(8'd44, 8'd44, 64'h3, 1'b1);
        calm = 1'b1;
        run_phase(300);
        calm = 1'b0;
        apply_setting(8'd34, CH_CR, 64'h6, 1'b0);
        run_phase(80);
        apply_setting(CH_LF, 8'd44, 64'h2, 1'b1);
        run_phase(80);

        phase = 0;
        while (bytes_sent < TARGET_BYTES) begin
            q   = 8'(($urandom_range(3) == 0) ? $urandom_range(255)
                                              : ($urandom_range(1) ? 34 : 39));
            s   = 8'(($urandom_range(3) == 0) ? $urandom_range(255)
                                              : ($urandom_range(1) ? 44 : 59));
            case ($urandom_range(5))
                0:       sel = {$urandom, $urandom};
                1:       sel = '0;
                2:       sel = '1;
                default: sel = 64'($urandom_range(1, 255));
            endcase
            apply_setting(q, s, sel, 1'($urandom_range(1)));
            run_phase($urandom_range(40, 120));
            phase++;
        end

        drain();
        repeat (10) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
